### sv/tmq_pkg.sv
// Shared types and constants of the tagged message queue.
package tmq_pkg;

  localparam int QueueDepthDef  = 16;
  localparam int TaskSlotsDef   = 16;
  localparam int HandleSlotsDef = 256;

  localparam logic [4:0] TASK_COUNT_RST = 5'd16;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_FRONT = 2'd1;
  localparam logic [1:0] KIND_RECV  = 2'd2;
  localparam logic [1:0] KIND_FIND  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_TASK    = 3'd1;
  localparam logic [2:0] ST_HANDLE_BUSY = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] event_id;
    logic [7:0] handle;
  } entry_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    entry_t     wdata;
    logic [7:0] raddr;
  } store_cmd_t;

endpackage

### sv/tmq_if.sv
// Request and response channel interfaces of the tagged message queue.
interface tmq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] task_req;
  logic [7:0] event_req;
  logic [7:0] handle;
  modport source (output valid, kind, task_req, event_req, handle, input ready);
  modport sink (input valid, kind, task_req, event_req, handle, output ready);
endinterface

interface tmq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] found_handle;
  logic [7:0] found_event;
  logic       pending;
  modport source (output valid, status, found_handle, found_event, pending, input ready);
  modport sink (input valid, status, found_handle, found_event, pending, output ready);
endinterface

### sv/tagged_message_queue.sv
// Tagged message queue: one ordered queue of messages shared by all tasks.
// Channels: req (kind, task_req, event_req, handle) and rsp (status,
// found_handle, found_event, pending), both valid/ready; a transfer happens
// when valid and ready are high at a clock edge. cfg_we/cfg_wdata write the
// task count; the user must write it only while the block is idle, and the
// block itself does not enforce this. One request is worked at a time;
// req.ready is high only between requests. Steps per request, with N
// entries queued: send writes the entry in the check state; push front
// moves all N entries back by one, then puts the new one at the head;
// receive scans up to the second entry for the task, then moves every entry
// behind the removed one forward; find scans until the first match or the
// end. The scan and the moves all go through the single registered read
// port of the entry memory. The response sits in an output register; a
// stalled receiver holds it, and req.ready stays low until it has gone; the
// next request can be taken in the cycle after the response transfer.
// Synchronous reset empties the queue, clears all pending and handle flags
// and sets the task count to 16; no clearing pass is needed.
module tagged_message_queue
  import tmq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QueueDepthDef,
  parameter int TASK_SLOTS   = TaskSlotsDef,
  parameter int HANDLE_SLOTS = HandleSlotsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  tmq_req_if.sink    req,
  tmq_rsp_if.source  rsp
);

  store_cmd_t cmd;
  entry_t     rdata;

  tmq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_SLOTS   (TASK_SLOTS),
    .HANDLE_SLOTS (HANDLE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .rdata     (rdata)
  );

  tmq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .cmd   (cmd),
    .rdata (rdata)
  );

endmodule

### sv/tmq_store.sv
// Entry memory of the queue: one write port, one registered read port.
module tmq_store #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  tmq_pkg::store_cmd_t cmd,
  output tmq_pkg::entry_t     rdata
);
  import tmq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr[AW-1:0]] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr[AW-1:0]];
  end

endmodule

### sv/tmq_ctrl.sv
// Sequencer of the queue: checks, scan and compare, entry moves and flags.
module tmq_ctrl #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_SLOTS   = 16,
  parameter int HANDLE_SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  tmq_req_if.sink             req,
  tmq_rsp_if.source           rsp,
  output tmq_pkg::store_cmd_t cmd,
  input  tmq_pkg::entry_t     rdata
);
  import tmq_pkg::*;

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TIW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int HF  = (HANDLE_SLOTS < 256) ? HANDLE_SLOTS : 256;
  localparam int HIW = $clog2(HF);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_CHK = 9'b000001000,
    S_SCAN_END = 9'b000010000,
    S_MOVE_RD  = 9'b000100000,
    S_MOVE_WR  = 9'b001000000,
    S_PUT      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;

  logic [1:0]          kind_r;
  logic [7:0]          task_r;
  logic [7:0]          event_r;
  logic [7:0]          handle_r;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       pos;
  logic                found;
  logic                more;
  logic [7:0]          cap_handle;
  logic [7:0]          cap_event;
  logic [4:0]          task_count;
  logic [TASK_SLOTS-1:0] tflags;
  logic [HF-1:0]       hflags;
  logic [2:0]          res_status;
  logic [7:0]          res_handle;
  logic [7:0]          res_event;
  logic                res_pend;

  logic [8:0]     limit;
  logic           bad_task;
  logic           handle_busy;
  logic [TIW-1:0] tidx;
  logic [HIW-1:0] hidx;
  logic [HIW-1:0] cap_hidx;
  logic           tflag;
  logic           task_hit;
  logic           last_idx;
  entry_t         new_entry;

  always_comb begin
    limit = ({4'b0, task_count} < 9'(TASK_SLOTS)) ? {4'b0, task_count} : 9'(TASK_SLOTS);
    bad_task = {1'b0, task_r} >= limit;
    tidx = task_r[TIW-1:0];
    hidx = handle_r[HIW-1:0];
    cap_hidx = cap_handle[HIW-1:0];
    tflag = tflags[tidx];
    handle_busy = (13'(handle_r) >= 13'(HANDLE_SLOTS)) || hflags[hidx];
    task_hit = rdata.task_id == task_r;
    last_idx = (idx + CW'(1)) == count;
    new_entry = '{task_id: task_r, event_id: event_r, handle: handle_r};
  end

  // Store port: one write and one read address per cycle
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CHECK: begin
        if (!bad_task && kind_r == KIND_SEND && !handle_busy &&
            count != CW'(QUEUE_DEPTH)) begin
          cmd.we    = 1'b1;
          cmd.waddr = 8'(count);
          cmd.wdata = new_entry;
        end
      end
      S_SCAN_RD: cmd.raddr = 8'(idx);
      S_MOVE_RD: cmd.raddr = (kind_r == KIND_FRONT) ? 8'(idx) : 8'(idx + CW'(1));
      S_MOVE_WR: begin
        cmd.we    = 1'b1;
        cmd.waddr = (kind_r == KIND_FRONT) ? 8'(idx + CW'(1)) : 8'(idx);
        cmd.wdata = rdata;
      end
      S_PUT: begin
        cmd.we    = 1'b1;
        cmd.wdata = new_entry;
      end
      default: ;
    endcase
  end

  // take a new request only once the previous response has gone
  assign req.ready        = (state == S_IDLE) && !rsp.valid;
  assign rsp.status       = res_status;
  assign rsp.found_handle = res_handle;
  assign rsp.found_event  = res_event;
  assign rsp.pending      = res_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      tflags     <= '0;
      hflags     <= '0;
      task_count <= TASK_COUNT_RST;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        task_count <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            kind_r   <= req.kind;
            task_r   <= req.task_req;
            event_r  <= req.event_req;
            handle_r <= req.handle;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_handle <= '0;
          res_event  <= '0;
          found      <= 1'b0;
          more       <= 1'b0;
          idx        <= '0;
          if (bad_task) begin
            res_status <= ST_BAD_TASK;
            res_pend   <= 1'b0;
            state      <= S_DONE;
          end else if (kind_r == KIND_SEND || kind_r == KIND_FRONT) begin
            res_pend <= tflag;
            if (handle_busy) begin
              res_status <= ST_HANDLE_BUSY;
              state      <= S_DONE;
            end else if (count == CW'(QUEUE_DEPTH)) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else if (kind_r == KIND_SEND) begin
              res_status   <= ST_OK;
              res_pend     <= 1'b1;
              count        <= count + CW'(1);
              hflags[hidx] <= 1'b1;
              tflags[tidx] <= 1'b1;
              state        <= S_DONE;
            end else if (count == '0) begin
              state <= S_PUT;
            end else begin
              idx   <= count - CW'(1);
              state <= S_MOVE_RD;
            end
          end else begin
            state <= (count == '0) ? S_SCAN_END : S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          state <= last_idx ? S_SCAN_END : S_SCAN_RD;
          idx   <= idx + CW'(1);
          if (kind_r == KIND_FIND) begin
            if (task_hit && rdata.event_id == event_r) begin
              found      <= 1'b1;
              cap_handle <= rdata.handle;
              cap_event  <= rdata.event_id;
              state      <= S_SCAN_END;
            end
          end else if (task_hit) begin
            if (!found) begin
              found      <= 1'b1;
              pos        <= idx;
              cap_handle <= rdata.handle;
              cap_event  <= rdata.event_id;
            end else begin
              more  <= 1'b1;
              state <= S_SCAN_END;
            end
          end
        end
        S_SCAN_END: begin
          res_status <= found ? ST_OK : ST_NOT_FOUND;
          res_handle <= found ? cap_handle : 8'd0;
          res_event  <= found ? cap_event : 8'd0;
          state      <= S_DONE;
          if (kind_r == KIND_FIND) begin
            res_pend <= tflag;
          end else begin
            res_pend     <= more;
            tflags[tidx] <= more;
            if (found) begin
              if (13'(cap_handle) < 13'(HANDLE_SLOTS)) begin
                hflags[cap_hidx] <= 1'b0;
              end
              // close the gap left by the removed entry
              if ((pos + CW'(1)) < count) begin
                idx   <= pos;
                state <= S_MOVE_RD;
              end else begin
                count <= count - CW'(1);
              end
            end
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          if (kind_r == KIND_FRONT) begin
            if (idx == '0) begin
              state <= S_PUT;
            end else begin
              idx   <= idx - CW'(1);
              state <= S_MOVE_RD;
            end
          end else if ((idx + CW'(2)) < count) begin
            idx   <= idx + CW'(1);
            state <= S_MOVE_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_PUT: begin
          res_status   <= ST_OK;
          res_pend     <= 1'b1;
          count        <= count + CW'(1);
          hflags[hidx] <= 1'b1;
          tflags[tidx] <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          // hold until the response register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
